@@ hdl/mfes_pkg.sv @@
// Shared types, constants and a helper function for the MIDI file event serializer.
// Used by the divider, the sequencer, the top level and the testbench; depends on nothing.
package mfes_pkg;

   localparam int DELTA_W    = 28;
   localparam int BPM_W      = 18;
   localparam int BYTE_W     = 8;
   localparam int TEMPO_W    = 24;
   localparam int DIVIDEND_W = 34;
   localparam int DIV_STEPS  = DIVIDEND_W;
   localparam int DIV_CNT_W  = $clog2(DIV_STEPS + 1);
   localparam int BODY_BYTES = 7;
   localparam int BODY_W     = BODY_BYTES * BYTE_W;
   localparam int BODY_CNT_W = $clog2(BODY_BYTES);
   localparam int VLQ_GRP_W  = 7;

   localparam logic [DIVIDEND_W-1:0] TEMPO_DIVIDEND = 34'd15360000000;

   localparam logic [1:0] FUNC_NOTE_OFF = 2'd0;
   localparam logic [1:0] FUNC_NOTE_ON  = 2'd1;
   localparam logic [1:0] FUNC_TEMPO    = 2'd2;
   localparam logic [1:0] FUNC_TIMESIG  = 2'd3;

   localparam logic [BYTE_W-1:0] STATUS_NOTE_OFF = 8'h80;
   localparam logic [BYTE_W-1:0] STATUS_NOTE_ON  = 8'h90;
   localparam logic [BYTE_W-1:0] META_PREFIX     = 8'hFF;
   localparam logic [BYTE_W-1:0] META_TEMPO      = 8'h51;
   localparam logic [BYTE_W-1:0] META_TEMPO_LEN  = 8'h03;
   localparam logic [BYTE_W-1:0] META_TIMESIG    = 8'h58;
   localparam logic [BYTE_W-1:0] META_TIMESIG_LEN = 8'h04;

   localparam logic [BODY_CNT_W-1:0] NOTE_BODY_LAST    = 3'd2;
   localparam logic [BODY_CNT_W-1:0] TEMPO_HDR_LAST    = 3'd2;
   localparam logic [BODY_CNT_W-1:0] TEMPO_DATA_LAST   = 3'd2;
   localparam logic [BODY_CNT_W-1:0] TIMESIG_BODY_LAST = 3'd6;

   typedef struct packed {
      logic [1:0]         func;
      logic [DELTA_W-1:0] delta_ticks;
      logic [3:0]         channel;
      logic [6:0]         pitch;
      logic [6:0]         velocity;
      logic [BPM_W-1:0]   bpm_q8;
      logic [7:0]         beats;
      logic [7:0]         note_value;
      logic [7:0]         clocks_per_click;
      logic [7:0]         thirty_seconds;
   } req_type;

   typedef struct packed {
      logic               done;
      logic [TEMPO_W-1:0] tempo;
   } div_stat_type;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_DELTA,
      ST_BODY,
      ST_TEMPO_WAIT,
      ST_TEMPO_DATA
   } ser_state_type;

   function automatic logic [BYTE_W-1:0] floor_log2(input logic [BYTE_W-1:0] x);
      logic [2:0] r;
      r = 3'd0;
      for (int i = 1; i < BYTE_W; i++) begin
         if (x[i]) begin
            r = 3'(i);
         end
      end
      return {5'b0, r};
   endfunction

endpackage

@@ hdl/mfes_div.sv @@
// Bit-serial restoring divider that turns a Q.8 tempo into microseconds per beat.
// One quotient bit per cycle, saturating at 24 bits; depends on mfes_pkg.
module mfes_div (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        load,
   input  logic [mfes_pkg::BPM_W-1:0]  divisor,
   output mfes_pkg::div_stat_type      stat
);

   logic [mfes_pkg::DIV_CNT_W-1:0]  count_ff, count_in;
   logic                            done_ff, done_in;
   logic [mfes_pkg::DIVIDEND_W-1:0] dq_ff, dq_in;
   logic [mfes_pkg::BPM_W-1:0]      rem_ff, rem_in;
   logic [mfes_pkg::BPM_W-1:0]      dvs_ff, dvs_in;
   logic [mfes_pkg::BPM_W:0]        trial;
   logic [mfes_pkg::BPM_W+1:0]      diff;
   logic                            qbit;

   assign trial = {rem_ff, dq_ff[mfes_pkg::DIVIDEND_W-1]};
   assign diff  = {1'b0, trial} - {2'b00, dvs_ff};
   assign qbit  = ~diff[mfes_pkg::BPM_W+1];

   always_comb begin
      count_in = count_ff;
      done_in  = done_ff;
      dq_in    = dq_ff;
      rem_in   = rem_ff;
      dvs_in   = dvs_ff;
      if (load) begin
         count_in = mfes_pkg::DIV_CNT_W'(mfes_pkg::DIV_STEPS);
         done_in  = 1'b0;
         dq_in    = mfes_pkg::TEMPO_DIVIDEND;
         rem_in   = '0;
         dvs_in   = divisor;
      end else if (count_ff != '0) begin
         count_in = count_ff - 1'b1;
         done_in  = (count_ff == mfes_pkg::DIV_CNT_W'(1));
         dq_in    = {dq_ff[mfes_pkg::DIVIDEND_W-2:0], qbit};
         rem_in   = qbit ? diff[mfes_pkg::BPM_W-1:0] : trial[mfes_pkg::BPM_W-1:0];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff <= '0;
         done_ff  <= 1'b0;
      end else begin
         count_ff <= count_in;
         done_ff  <= done_in;
      end
      dq_ff  <= dq_in;
      rem_ff <= rem_in;
      dvs_ff <= dvs_in;
   end

   assign stat.done  = done_ff;
   assign stat.tempo = (dq_ff[mfes_pkg::DIVIDEND_W-1:mfes_pkg::TEMPO_W] != '0) ?
                       {mfes_pkg::TEMPO_W{1'b1}} : dq_ff[mfes_pkg::TEMPO_W-1:0];

endmodule

@@ hdl/mfes_ser.sv @@
// Byte sequencer: shifts out the delta-time groups and the event body one byte per cycle,
// pausing while it waits for the tempo quotient from mfes_div; depends on mfes_pkg.
module mfes_ser (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          load,
   input  mfes_pkg::req_type             req,
   input  mfes_pkg::div_stat_type        div,
   output logic                          busy,
   output logic                          out_strobe,
   output logic [mfes_pkg::BYTE_W-1:0]   out_byte,
   output logic                          out_last
);

   mfes_pkg::ser_state_type             state_ff, state_in;
   logic [mfes_pkg::DELTA_W-1:0]        delta_ff, delta_in;
   logic [1:0]                          vlq_cnt_ff, vlq_cnt_in;
   logic [mfes_pkg::BODY_W-1:0]         body_ff, body_in;
   logic [mfes_pkg::BODY_CNT_W-1:0]     body_cnt_ff, body_cnt_in;
   logic                                tempo_ff, tempo_in;
   logic                                strobe_ff, strobe_in;
   logic [mfes_pkg::BYTE_W-1:0]         byte_ff, byte_in;
   logic                                last_ff, last_in;
   logic [1:0]                          grp_extra;
   logic [mfes_pkg::DELTA_W-1:0]        delta_aligned;
   logic [mfes_pkg::BYTE_W-1:0]         status;
   logic [mfes_pkg::BODY_W-1:0]         body_load;
   logic [mfes_pkg::BODY_CNT_W-1:0]     body_cnt_load;

   always_comb begin
      priority if (req.delta_ticks[27:21] != '0) begin
         grp_extra = 2'd3;
      end else if (req.delta_ticks[20:14] != '0) begin
         grp_extra = 2'd2;
      end else if (req.delta_ticks[13:7] != '0) begin
         grp_extra = 2'd1;
      end else begin
         grp_extra = 2'd0;
      end
   end

   always_comb begin
      unique case (grp_extra)
         2'd3:    delta_aligned = req.delta_ticks;
         2'd2:    delta_aligned = {req.delta_ticks[20:0], 7'b0};
         2'd1:    delta_aligned = {req.delta_ticks[13:0], 14'b0};
         default: delta_aligned = {req.delta_ticks[6:0], 21'b0};
      endcase
   end

   assign status = ((req.func == mfes_pkg::FUNC_NOTE_ON) ? mfes_pkg::STATUS_NOTE_ON
                                                          : mfes_pkg::STATUS_NOTE_OFF)
                   | {4'b0, req.channel};

   always_comb begin
      unique case (req.func)
         mfes_pkg::FUNC_NOTE_OFF, mfes_pkg::FUNC_NOTE_ON: begin
            body_load     = {status, 1'b0, req.pitch, 1'b0, req.velocity, 32'b0};
            body_cnt_load = mfes_pkg::NOTE_BODY_LAST;
         end
         mfes_pkg::FUNC_TEMPO: begin
            body_load     = {mfes_pkg::META_PREFIX, mfes_pkg::META_TEMPO,
                             mfes_pkg::META_TEMPO_LEN, 32'b0};
            body_cnt_load = mfes_pkg::TEMPO_HDR_LAST;
         end
         default: begin
            body_load     = {mfes_pkg::META_PREFIX, mfes_pkg::META_TIMESIG,
                             mfes_pkg::META_TIMESIG_LEN, req.beats,
                             mfes_pkg::floor_log2(req.note_value),
                             req.clocks_per_click, req.thirty_seconds};
            body_cnt_load = mfes_pkg::TIMESIG_BODY_LAST;
         end
      endcase
   end

   // Next state.
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         mfes_pkg::ST_IDLE: begin
            if (load) begin
               state_in = mfes_pkg::ST_DELTA;
            end
         end
         mfes_pkg::ST_DELTA: begin
            if (vlq_cnt_ff == '0) begin
               state_in = mfes_pkg::ST_BODY;
            end
         end
         mfes_pkg::ST_BODY: begin
            if (body_cnt_ff == '0) begin
               state_in = tempo_ff ? mfes_pkg::ST_TEMPO_WAIT : mfes_pkg::ST_IDLE;
            end
         end
         mfes_pkg::ST_TEMPO_WAIT: begin
            if (div.done) begin
               state_in = mfes_pkg::ST_TEMPO_DATA;
            end
         end
         mfes_pkg::ST_TEMPO_DATA: begin
            if (body_cnt_ff == '0) begin
               state_in = mfes_pkg::ST_IDLE;
            end
         end
         default: state_in = mfes_pkg::ST_IDLE;
      endcase
   end

   // Datapath and outputs.
   always_comb begin
      delta_in    = delta_ff;
      vlq_cnt_in  = vlq_cnt_ff;
      body_in     = body_ff;
      body_cnt_in = body_cnt_ff;
      tempo_in    = tempo_ff;
      strobe_in   = 1'b0;
      byte_in     = byte_ff;
      last_in     = 1'b0;
      unique case (state_ff)
         mfes_pkg::ST_IDLE: begin
            if (load) begin
               delta_in    = delta_aligned;
               vlq_cnt_in  = grp_extra;
               body_in     = body_load;
               body_cnt_in = body_cnt_load;
               tempo_in    = (req.func == mfes_pkg::FUNC_TEMPO);
            end
         end
         mfes_pkg::ST_DELTA: begin
            strobe_in  = 1'b1;
            byte_in    = {vlq_cnt_ff != '0, delta_ff[27:21]};
            delta_in   = {delta_ff[20:0], 7'b0};
            vlq_cnt_in = vlq_cnt_ff - 1'b1;
         end
         mfes_pkg::ST_BODY, mfes_pkg::ST_TEMPO_DATA: begin
            strobe_in   = 1'b1;
            byte_in     = body_ff[mfes_pkg::BODY_W-1 -: mfes_pkg::BYTE_W];
            body_in     = {body_ff[mfes_pkg::BODY_W-mfes_pkg::BYTE_W-1:0],
                           {mfes_pkg::BYTE_W{1'b0}}};
            body_cnt_in = body_cnt_ff - 1'b1;
            last_in     = (body_cnt_ff == '0) &&
                          ((state_ff == mfes_pkg::ST_TEMPO_DATA) || !tempo_ff);
         end
         mfes_pkg::ST_TEMPO_WAIT: begin
            if (div.done) begin
               body_in     = {div.tempo, 32'b0};
               body_cnt_in = mfes_pkg::TEMPO_DATA_LAST;
            end
         end
         default: begin
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff  <= mfes_pkg::ST_IDLE;
         strobe_ff <= 1'b0;
         last_ff   <= 1'b0;
      end else begin
         state_ff  <= state_in;
         strobe_ff <= strobe_in;
         last_ff   <= last_in;
      end
      delta_ff    <= delta_in;
      vlq_cnt_ff  <= vlq_cnt_in;
      body_ff     <= body_in;
      body_cnt_ff <= body_cnt_in;
      tempo_ff    <= tempo_in;
      byte_ff     <= byte_in;
   end

   assign busy       = (state_ff != mfes_pkg::ST_IDLE);
   assign out_strobe = strobe_ff;
   assign out_byte   = byte_ff;
   assign out_last   = last_ff;

endmodule

@@ hdl/midi_file_event_serializer_top.sv @@
// Top level of the MIDI file event serializer: command handshake, tempo divider, byte sequencer.
// Instantiates mfes_div and mfes_ser; depends on mfes_pkg.
//
// An event is taken at a rising edge where start is high and busy is low; all req_ ports
// are sampled at that edge. The block then emits the event's Standard MIDI File bytes,
// one word per cycle on rsp_out_byte, except while set tempo waits for the divider; each
// word is marked by rsp_strobe for one cycle, with rsp_last high on the final word. The
// delta time comes first as 1 to 4 words. The first word is registered: the accepting
// edge moves the sequencer into its delta state, and the word then passes through the
// output register. Set tempo waits for the 34-step bit-serial divider that starts at the
// accepting edge; the header words go out while it runs, the data words after it is done.
// A new event can be taken once busy is low again; none is taken while busy is high.
// Synchronous reset returns the block to idle and drops any event in progress.
// The receiver cannot stall: every word must be taken in the cycle it is shown.
module midi_file_event_serializer_top (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              start,
   output logic                              busy,
   input  logic [1:0]                        req_func,
   input  logic [mfes_pkg::DELTA_W-1:0]      req_delta_ticks,
   input  logic [3:0]                        req_channel,
   input  logic [6:0]                        req_pitch,
   input  logic [6:0]                        req_velocity,
   input  logic [mfes_pkg::BPM_W-1:0]        req_bpm_q8,
   input  logic [7:0]                        req_beats,
   input  logic [7:0]                        req_note_value,
   input  logic [7:0]                        req_clocks_per_click,
   input  logic [7:0]                        req_thirty_seconds,
   output logic                              rsp_strobe,
   output logic [mfes_pkg::BYTE_W-1:0]       rsp_out_byte,
   output logic                              rsp_last
);

   logic                   accept;
   mfes_pkg::req_type      req;
   mfes_pkg::div_stat_type div_stat;

   assign accept = start & ~busy;

   assign req.func             = req_func;
   assign req.delta_ticks      = req_delta_ticks;
   assign req.channel          = req_channel;
   assign req.pitch            = req_pitch;
   assign req.velocity         = req_velocity;
   assign req.bpm_q8           = req_bpm_q8;
   assign req.beats            = req_beats;
   assign req.note_value       = req_note_value;
   assign req.clocks_per_click = req_clocks_per_click;
   assign req.thirty_seconds   = req_thirty_seconds;

   mfes_div u_div (
      .clock   (clock),
      .reset   (reset),
      .load    (accept),
      .divisor (req.bpm_q8),
      .stat    (div_stat)
   );

   mfes_ser u_ser (
      .clock      (clock),
      .reset      (reset),
      .load       (accept),
      .req        (req),
      .div        (div_stat),
      .busy       (busy),
      .out_strobe (rsp_strobe),
      .out_byte   (rsp_out_byte),
      .out_last   (rsp_last)
   );

endmodule

@@ hdl/mfes_checker.sv @@
// Port-level checker for the MIDI file event serializer, bound to the top level.
// Sees only the top level's handshake ports; depends on nothing else.
module mfes_checker (
   input logic clock,
   input logic reset,
   input logic start,
   input logic busy,
   input logic rsp_strobe,
   input logic rsp_last
);

   a_accept_busy: assert property (@(posedge clock) disable iff (reset)
      start && !busy |=> busy)
      else $error("Block did not go busy after taking an event.");

   a_last_gap: assert property (@(posedge clock) disable iff (reset)
      rsp_strobe && rsp_last |=> !rsp_strobe)
      else $error("A word followed the last word of an event directly.");

   a_idle_words: assert property (@(posedge clock) disable iff (reset)
      !busy && rsp_strobe |-> rsp_last)
      else $error("A word other than the last appeared while idle.");

   a_end_last: assert property (@(posedge clock) disable iff (reset)
      $fell(busy) |-> rsp_strobe && rsp_last)
      else $error("Event ended without a last word.");

   a_last_strobe: assert property (@(posedge clock) disable iff (reset)
      rsp_last |-> rsp_strobe)
      else $error("Last flag without a word.");

endmodule

bind midi_file_event_serializer_top mfes_checker u_mfes_checker (
   .clock      (clock),
   .reset      (reset),
   .start      (start),
   .busy       (busy),
   .rsp_strobe (rsp_strobe),
   .rsp_last   (rsp_last)
);

@@ tb/midi_file_event_serializer_top_tb.sv @@
// Self-checking testbench for midi_file_event_serializer_top: a table of directed events,
// then random events, every output word checked against fixed expected bytes from the table
// or a behavioral encoder of SMF events. Depends on mfes_pkg and the top level of the block only.
module midi_file_event_serializer_top_tb;
   timeunit 1ns;
   timeprecision 1ps;

   localparam int          CLK_HALF     = 5;
   localparam int          RESET_CYCLES = 10;
   localparam int          TAIL_CYCLES  = 60;
   localparam int          RANDOM_ITEMS = 237;
   localparam int          MAX_WORDS    = 11;
   localparam longint      TIMEOUT_NS   = 5_000_000;
   localparam logic [63:0] US_DIVIDEND  = 64'd15360000000;
   localparam logic [63:0] US_MAX       = 64'hFFFFFF;

   typedef struct packed {
      logic [7:0] value;
      logic       last;
   } smf_word_type;

   typedef struct packed {
      mfes_pkg::req_type ev;
      logic [3:0]        gold_n;
      logic [87:0]       gold;
   } stim_row_type;

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic start = 1'b0;
   logic busy;
   logic [1:0]                   req_func = '0;
   logic [mfes_pkg::DELTA_W-1:0] req_delta_ticks = '0;
   logic [3:0]                   req_channel = '0;
   logic [6:0]                   req_pitch = '0;
   logic [6:0]                   req_velocity = '0;
   logic [mfes_pkg::BPM_W-1:0]   req_bpm_q8 = '0;
   logic [7:0]                   req_beats = '0;
   logic [7:0]                   req_note_value = '0;
   logic [7:0]                   req_clocks_per_click = '0;
   logic [7:0]                   req_thirty_seconds = '0;
   logic                         rsp_strobe;
   logic [mfes_pkg::BYTE_W-1:0]  rsp_out_byte;
   logic                         rsp_last;

   smf_word_type staged_words [$];
   smf_word_type expected_words [$];
   smf_word_type head_word;
   stim_row_type directed_table [$];
   int unsigned  mismatch_count = 0;
   int unsigned  words_checked  = 0;
   int unsigned  kind_count [4] = '{0, 0, 0, 0};

   midi_file_event_serializer_top uut (
      .clock                (clock),
      .reset                (reset),
      .start                (start),
      .busy                 (busy),
      .req_func             (req_func),
      .req_delta_ticks      (req_delta_ticks),
      .req_channel          (req_channel),
      .req_pitch            (req_pitch),
      .req_velocity         (req_velocity),
      .req_bpm_q8           (req_bpm_q8),
      .req_beats            (req_beats),
      .req_note_value       (req_note_value),
      .req_clocks_per_click (req_clocks_per_click),
      .req_thirty_seconds   (req_thirty_seconds),
      .rsp_strobe           (rsp_strobe),
      .rsp_out_byte         (rsp_out_byte),
      .rsp_last             (rsp_last)
   );

   always #(CLK_HALF) clock = ~clock;

   initial begin
      #(TIMEOUT_NS);
      $display("Timeout with %0d words still expected", expected_words.size());
      $display("Testbench completed WITH ERRORS");
      $finish;
   end

   task automatic report_mismatch(input string what, input logic [7:0] got,
                                  input logic [7:0] want);
      mismatch_count++;
      $display("%0t: %s mismatch: got %02h, expected %02h", $realtime, what, got, want);
   endtask

   function automatic void stage_encoding(input mfes_pkg::req_type ev);
      logic [7:0]   word_list [MAX_WORDS];
      logic [63:0]  us_per_beat;
      logic [27:0]  delta;
      logic [7:0]   log_val;
      logic [7:0]   nv;
      int unsigned  groups;
      int unsigned  n;
      smf_word_type w;
      n = 0;
      delta = ev.delta_ticks;
      groups = 1;
      while (groups < 4 && (delta >> (7 * groups)) != 0) begin
         groups++;
      end
      for (int g = int'(groups) - 1; g >= 0; g--) begin
         word_list[n] = {(g != 0), 7'((delta >> (7 * g)) & 28'h7F)};
         n++;
      end
      case (ev.func)
         mfes_pkg::FUNC_NOTE_OFF, mfes_pkg::FUNC_NOTE_ON: begin
            word_list[n]   = ((ev.func == mfes_pkg::FUNC_NOTE_OFF) ? mfes_pkg::STATUS_NOTE_OFF
                                                                  : mfes_pkg::STATUS_NOTE_ON)
                             + {4'b0, ev.channel};
            word_list[n+1] = {1'b0, ev.pitch};
            word_list[n+2] = {1'b0, ev.velocity};
            n += 3;
         end
         mfes_pkg::FUNC_TEMPO: begin
            us_per_beat = US_MAX;
            if (ev.bpm_q8 != 0) begin
               us_per_beat = US_DIVIDEND / 64'(ev.bpm_q8);
               if (us_per_beat > US_MAX) begin
                  us_per_beat = US_MAX;
               end
            end
            word_list[n]   = mfes_pkg::META_PREFIX;
            word_list[n+1] = mfes_pkg::META_TEMPO;
            word_list[n+2] = mfes_pkg::META_TEMPO_LEN;
            word_list[n+3] = us_per_beat[23:16];
            word_list[n+4] = us_per_beat[15:8];
            word_list[n+5] = us_per_beat[7:0];
            n += 6;
         end
         default: begin
            nv = ev.note_value;
            log_val = 8'd0;
            while (nv > 8'd1) begin
               nv = nv >> 1;
               log_val++;
            end
            word_list[n]   = mfes_pkg::META_PREFIX;
            word_list[n+1] = mfes_pkg::META_TIMESIG;
            word_list[n+2] = mfes_pkg::META_TIMESIG_LEN;
            word_list[n+3] = ev.beats;
            word_list[n+4] = log_val;
            word_list[n+5] = ev.clocks_per_click;
            word_list[n+6] = ev.thirty_seconds;
            n += 7;
         end
      endcase
      for (int unsigned i = 0; i < n; i++) begin
         w.value = word_list[i];
         w.last  = (i == n - 1);
         staged_words = {staged_words, w};
      end
   endfunction

   function automatic stim_row_type make_row(input logic [1:0] func, input logic [27:0] delta,
                                             input logic [3:0] channel,
                                             input logic [6:0] pitch,
                                             input logic [6:0] velocity,
                                             input logic [17:0] bpm,
                                             input logic [7:0] beats, input logic [7:0] nv,
                                             input logic [7:0] cpc, input logic [7:0] ts,
                                             input logic [3:0] gold_n,
                                             input logic [87:0] gold);
      stim_row_type row;
      row.ev.func             = func;
      row.ev.delta_ticks      = delta;
      row.ev.channel          = channel;
      row.ev.pitch            = pitch;
      row.ev.velocity         = velocity;
      row.ev.bpm_q8           = bpm;
      row.ev.beats            = beats;
      row.ev.note_value       = nv;
      row.ev.clocks_per_click = cpc;
      row.ev.thirty_seconds   = ts;
      row.gold_n              = gold_n;
      row.gold                = gold;
      return row;
   endfunction

   always @(posedge clock) begin
      if (!reset) begin
         if (rsp_strobe) begin
            if (expected_words.size() == 0) begin
               report_mismatch("unexpected word", rsp_out_byte, 8'h00);
            end else begin
               head_word = expected_words.pop_front();
               words_checked++;
               if (rsp_out_byte !== head_word.value) begin
                  report_mismatch("byte", rsp_out_byte, head_word.value);
               end
               if (rsp_last !== head_word.last) begin
                  report_mismatch("last flag", {7'b0, rsp_last}, {7'b0, head_word.last});
               end
            end
         end
         if (start && !busy) begin
            expected_words = {expected_words, staged_words};
            staged_words.delete();
         end
      end
   end

   task automatic send_event(input mfes_pkg::req_type ev, input logic [3:0] gold_n,
                             input logic [87:0] gold, input int unsigned gap);
      smf_word_type w;
      repeat (gap) begin
         @(negedge clock);
         start <= 1'b0;
      end
      @(negedge clock);
      req_func             <= ev.func;
      req_delta_ticks      <= ev.delta_ticks;
      req_channel          <= ev.channel;
      req_pitch            <= ev.pitch;
      req_velocity         <= ev.velocity;
      req_bpm_q8           <= ev.bpm_q8;
      req_beats            <= ev.beats;
      req_note_value       <= ev.note_value;
      req_clocks_per_click <= ev.clocks_per_click;
      req_thirty_seconds   <= ev.thirty_seconds;
      start                <= 1'b1;
      if (gold_n != 0) begin
         for (int unsigned i = 0; i < gold_n; i++) begin
            w.value = gold[(gold_n - 1 - i) * 8 +: 8];
            w.last  = (i == gold_n - 1);
            staged_words = {staged_words, w};
         end
      end else begin
         stage_encoding(ev);
      end
      kind_count[ev.func]++;
      do begin
         @(posedge clock);
      end while (busy !== 1'b0);
   endtask

   task automatic wait_until_drained();
      @(negedge clock);
      start <= 1'b0;
      while (expected_words.size() != 0 || staged_words.size() != 0) begin
         @(posedge clock);
      end
      repeat (TAIL_CYCLES) @(posedge clock);
   endtask

   initial begin
      mfes_pkg::req_type ev;
      int unsigned       gap;
      bit                no_idle;
      directed_table = {directed_table,
                        make_row(mfes_pkg::FUNC_NOTE_ON, 28'd0, 4'd0, 7'd60, 7'd100, 18'd0,
                                 8'd0, 8'd0, 8'd0, 8'd0, 4'd4, 88'h00903C64)};
      directed_table = {directed_table,
                        make_row(mfes_pkg::FUNC_NOTE_OFF, 28'd0, 4'd15, 7'd127, 7'd127, 18'd0,
                                 8'd0, 8'd0, 8'd0, 8'd0, 4'd4, 88'h008F7F7F)};
      directed_table = {directed_table,
                        make_row(mfes_pkg::FUNC_NOTE_ON, 28'd0, 4'd0, 7'd0, 7'd0, 18'd0,
                                 8'd0, 8'd0, 8'd0, 8'd0, 4'd4, 88'h00900000)};
      directed_table = {directed_table,
                        make_row(mfes_pkg::FUNC_NOTE_OFF, 28'd127, 4'd5, 7'd64, 7'd0, 18'd0,
                                 8'd0, 8'd0, 8'd0, 8'd0, 4'd4, 88'h7F854000)};
      directed_table = {directed_table,
                        make_row(mfes_pkg::FUNC_NOTE_ON, 28'd128, 4'd9, 7'd36, 7'd127, 18'd0,
                                 8'd0, 8'd0, 8'd0, 8'd0, 4'd5, 88'h810099247F)};
      directed_table = {directed_table,
                        make_row(mfes_pkg::FUNC_NOTE_ON, 28'd16383, 4'd0, 7'd1, 7'd1, 18'd0,
                                 8'd0, 8'd0, 8'd0, 8'd0, 4'd5, 88'hFF7F900101)};
      directed_table = {directed_table,
                        make_row(mfes_pkg::FUNC_NOTE_OFF, 28'd16384, 4'd0, 7'd1, 7'd1, 18'd0,
                                 8'd0, 8'd0, 8'd0, 8'd0, 4'd6, 88'h818000800101)};
      directed_table = {directed_table,
                        make_row(mfes_pkg::FUNC_NOTE_ON, 28'd2097151, 4'd0, 7'd1, 7'd1, 18'd0,
                                 8'd0, 8'd0, 8'd0, 8'd0, 4'd6, 88'hFFFF7F900101)};
      directed_table = {directed_table,
                        make_row(mfes_pkg::FUNC_NOTE_ON, 28'd2097152, 4'd0, 7'd1, 7'd1, 18'd0,
                                 8'd0, 8'd0, 8'd0, 8'd0, 4'd7, 88'h81808000900101)};
      directed_table = {directed_table,
                        make_row(mfes_pkg::FUNC_NOTE_OFF, 28'hFFFFFFF, 4'd15, 7'd127, 7'd127,
                                 18'd0, 8'd0, 8'd0, 8'd0, 8'd0, 4'd7,
                                 88'hFFFFFF7F8F7F7F)};
      directed_table = {directed_table,
                        make_row(mfes_pkg::FUNC_NOTE_ON, 28'd1000, 4'd3, 7'd72, 7'd90,
                                 18'h3FFFF, 8'hFF, 8'hFF, 8'hFF, 8'hFF, 4'd0, 88'h0)};
      directed_table = {directed_table,
                        make_row(mfes_pkg::FUNC_TEMPO, 28'd0, 4'd0, 7'd0, 7'd0, 18'd30720,
                                 8'd0, 8'd0, 8'd0, 8'd0, 4'd7, 88'h00FF510307A120)};
      directed_table = {directed_table,
                        make_row(mfes_pkg::FUNC_TEMPO, 28'd0, 4'd0, 7'd0, 7'd0, 18'd0,
                                 8'd0, 8'd0, 8'd0, 8'd0, 4'd7, 88'h00FF5103FFFFFF)};
      directed_table = {directed_table,
                        make_row(mfes_pkg::FUNC_TEMPO, 28'd0, 4'd0, 7'd0, 7'd0, 18'd255,
                                 8'd0, 8'd0, 8'd0, 8'd0, 4'd7, 88'h00FF5103FFFFFF)};
      directed_table = {directed_table,
                        make_row(mfes_pkg::FUNC_TEMPO, 28'd0, 4'd0, 7'd0, 7'd0, 18'd256,
                                 8'd0, 8'd0, 8'd0, 8'd0, 4'd7, 88'h00FF5103FFFFFF)};
      directed_table = {directed_table,
                        make_row(mfes_pkg::FUNC_TEMPO, 28'd0, 4'd0, 7'd0, 7'd0, 18'd915,
                                 8'd0, 8'd0, 8'd0, 8'd0, 4'd7, 88'h00FF5103FFFFFF)};
      directed_table = {directed_table,
                        make_row(mfes_pkg::FUNC_TEMPO, 28'd0, 4'd0, 7'd0, 7'd0, 18'd916,
                                 8'd0, 8'd0, 8'd0, 8'd0, 4'd0, 88'h0)};
      directed_table = {directed_table,
                        make_row(mfes_pkg::FUNC_TEMPO, 28'hFFFFFFF, 4'hF, 7'h7F, 7'h7F,
                                 18'h3FFFF, 8'hFF, 8'hFF, 8'hFF, 8'hFF, 4'd0, 88'h0)};
      directed_table = {directed_table,
                        make_row(mfes_pkg::FUNC_TIMESIG, 28'd0, 4'd0, 7'd0, 7'd0, 18'd0,
                                 8'd4, 8'd4, 8'd24, 8'd8, 4'd8, 88'h00FF580404021808)};
      directed_table = {directed_table,
                        make_row(mfes_pkg::FUNC_TIMESIG, 28'd0, 4'd0, 7'd0, 7'd0, 18'd0,
                                 8'd0, 8'd0, 8'd0, 8'd0, 4'd8, 88'h00FF580400000000)};
      directed_table = {directed_table,
                        make_row(mfes_pkg::FUNC_TIMESIG, 28'hFFFFFFF, 4'd0, 7'd0, 7'd0, 18'd0,
                                 8'hFF, 8'hFF, 8'hFF, 8'hFF, 4'd11,
                                 88'hFFFFFF7FFF5804FF07FFFF)};
      directed_table = {directed_table,
                        make_row(mfes_pkg::FUNC_TIMESIG, 28'd200, 4'hF, 7'h7F, 7'h7F,
                                 18'h3FFFF, 8'd3, 8'd1, 8'd36, 8'd8, 4'd0, 88'h0)};
      directed_table = {directed_table,
                        make_row(mfes_pkg::FUNC_TIMESIG, 28'd5, 4'd0, 7'd0, 7'd0, 18'd0,
                                 8'd6, 8'd128, 8'd1, 8'd255, 4'd0, 88'h0)};

      repeat (RESET_CYCLES) @(negedge clock);
      reset <= 1'b0;

      foreach (directed_table[i]) begin
         send_event(directed_table[i].ev, directed_table[i].gold_n, directed_table[i].gold,
                    $urandom_range(0, 8));
      end
      wait_until_drained();

      no_idle = 1'b0;
      for (int unsigned k = 0; k < RANDOM_ITEMS; k++) begin
         if (k % 20 == 0) begin
            no_idle = ($urandom_range(0, 3) == 0);
         end
         if (k == RANDOM_ITEMS / 2) begin
            wait_until_drained();
         end
         ev.func             = 2'($urandom_range(0, 3));
         ev.channel          = 4'($urandom);
         ev.pitch            = 7'($urandom);
         ev.velocity         = 7'($urandom);
         ev.beats            = 8'($urandom);
         ev.clocks_per_click = 8'($urandom);
         ev.thirty_seconds   = 8'($urandom);
         case ($urandom_range(0, 6))
            0: ev.delta_ticks = 28'($urandom_range(0, 127));
            1: ev.delta_ticks = 28'($urandom_range(128, 16383));
            2: ev.delta_ticks = 28'($urandom_range(16384, 2097151));
            3: ev.delta_ticks = 28'($urandom_range(2097152, 28'hFFFFFFF));
            4: ev.delta_ticks = 28'(1 << $urandom_range(0, 27)) - 28'($urandom_range(0, 1));
            default: ev.delta_ticks = 28'($urandom);
         endcase
         case ($urandom_range(0, 3))
            0: ev.bpm_q8 = 18'($urandom_range(0, 1023));
            1: ev.bpm_q8 = 18'($urandom_range(256 * 40, 256 * 300));
            default: ev.bpm_q8 = 18'($urandom);
         endcase
         if ($urandom_range(0, 1) == 0) begin
            ev.note_value = 8'(1 << $urandom_range(0, 7));
         end else begin
            ev.note_value = 8'($urandom);
         end
         gap = no_idle ? 0 : $urandom_range(0, 8);
         send_event(ev, 4'd0, 88'h0, gap);
      end
      wait_until_drained();

      $display("Sent %0d note off, %0d note on, %0d set tempo, %0d time signature events;",
               kind_count[mfes_pkg::FUNC_NOTE_OFF], kind_count[mfes_pkg::FUNC_NOTE_ON],
               kind_count[mfes_pkg::FUNC_TEMPO], kind_count[mfes_pkg::FUNC_TIMESIG]);
      $display("%0d output words compared, %0d mismatches.", words_checked, mismatch_count);
      if (mismatch_count == 0 && expected_words.size() == 0) begin
         $display("Testbench completed without errors");
      end else begin
         $display("Testbench completed WITH ERRORS");
      end
      $finish;
   end

endmodule
